// ----- rtl/hpv_pkg.sv -----
// ----------------------------------------------------------------------------
// hpv_pkg
// Shared widths, result codes and the record types that pass between the
// detector core, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package hpv_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned INDEX_BITS  = 16;
  localparam int unsigned HYST_BITS   = 15;

  // Compare width: room for a sample plus or minus the full threshold.
  localparam int unsigned CMP_BITS =
      ((SAMPLE_BITS > HYST_BITS) ? SAMPLE_BITS : HYST_BITS) + 2;

  // The result queue holds two results per word in flight plus slack.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PUSH_BITS  = 2;

  localparam logic KIND_MAX = 1'b0;
  localparam logic KIND_MIN = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic [INDEX_BITS-1:0]         pos;
    logic signed [SAMPLE_BITS-1:0] level;
    logic                          last;
  } result_t;

  typedef struct packed {
    logic [PUSH_BITS-1:0] count;
    result_t              first;
    result_t              second;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/hpv_core.sv -----
// ----------------------------------------------------------------------------
// hpv_core
// Candidate tracking and extremum confirmation: one sample per step_i cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hpv_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  step_i,
  input  wire logic signed [hpv_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                                  stream_end_i,
  input  wire logic [hpv_pkg::HYST_BITS-1:0]         hyst_i,
  output hpv_pkg::push_t                             push_o
);

  logic                                  seek_q, seek_d;
  logic [hpv_pkg::INDEX_BITS-1:0]        maxp_q, maxp_d, minp_q, minp_d;
  logic signed [hpv_pkg::SAMPLE_BITS-1:0] maxl_q, maxl_d, minl_q, minl_d;
  logic [hpv_pkg::INDEX_BITS-1:0]        idx_q, idx_d;
  logic                                  maxr_q, maxr_d, minr_q, minr_d;

  logic signed [hpv_pkg::CMP_BITS-1:0] x_w, t_w;
  hpv_pkg::result_t                    res [2];
  logic [1:0]                          n;

  assign x_w = hpv_pkg::CMP_BITS'(sample_i);
  assign t_w = hpv_pkg::CMP_BITS'($signed({1'b0, hyst_i}));

  always_comb begin
    seek_d = seek_q;
    maxp_d = maxp_q;
    maxl_d = maxl_q;
    minp_d = minp_q;
    minl_d = minl_q;
    maxr_d = maxr_q;
    minr_d = minr_q;
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;

    if (idx_q == '0) begin
      maxp_d = '0;
      minp_d = '0;
      maxl_d = sample_i;
      minl_d = sample_i;
    end else begin
      // The second sample fixes the initial search direction.
      if (idx_q == hpv_pkg::INDEX_BITS'(1)) begin
        seek_d = (maxl_q >= sample_i);
      end

      if (seek_d && (x_w < hpv_pkg::CMP_BITS'(maxl_q) - t_w)) begin
        if (maxp_q != '0) begin
          res[0] = '{kind: hpv_pkg::KIND_MAX, pos: maxp_q, level: maxl_q, last: 1'b0};
          n      = 2'd1;
          maxr_d = 1'b1;
        end
        seek_d = 1'b0;
        minp_d = idx_q;
        minl_d = sample_i;
      end else if (!seek_d && (x_w > hpv_pkg::CMP_BITS'(minl_q) + t_w)) begin
        if (minp_q != '0) begin
          res[0] = '{kind: hpv_pkg::KIND_MIN, pos: minp_q, level: minl_q, last: 1'b0};
          n      = 2'd1;
          minr_d = 1'b1;
        end
        seek_d = 1'b1;
        maxp_d = idx_q;
        maxl_d = sample_i;
      end

      if (seek_d && (sample_i > maxl_d)) begin
        maxp_d = idx_q;
        maxl_d = sample_i;
      end else if (!seek_d && (sample_i < minl_d)) begin
        minp_d = idx_q;
        minl_d = sample_i;
      end
    end

    // The index sticks at its top value on very long streams.
    idx_d = (idx_q != '1) ? idx_q + 1'b1 : idx_q;

    if (stream_end_i) begin
      // At most one result came from the stream part, so the minimum fits.
      if (!minr_d) begin
        res[n[0]] = '{kind: hpv_pkg::KIND_MIN, pos: minp_d, level: minl_d, last: 1'b0};
        n         = n + 2'd1;
      end
      if (!maxr_d && (n != 2'd2)) begin
        res[n[0]] = '{kind: hpv_pkg::KIND_MAX, pos: maxp_d, level: maxl_d, last: 1'b0};
        n         = n + 2'd1;
      end
      seek_d = 1'b0;
      maxp_d = '0;
      maxl_d = '0;
      minp_d = '0;
      minl_d = '0;
      idx_d  = '0;
      maxr_d = 1'b0;
      minr_d = 1'b0;
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end

    push_o.count  = step_i ? n : 2'd0;
    push_o.first  = res[0];
    push_o.second = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_q <= 1'b0;
      maxp_q <= '0;
      maxl_q <= '0;
      minp_q <= '0;
      minl_q <= '0;
      idx_q  <= '0;
      maxr_q <= 1'b0;
      minr_q <= 1'b0;
    end else if (step_i) begin
      seek_q <= seek_d;
      maxp_q <= maxp_d;
      maxl_q <= maxl_d;
      minp_q <= minp_d;
      minl_q <= minl_d;
      idx_q  <= idx_d;
      maxr_q <= maxr_d;
      minr_q <= minr_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hpv_fifo.sv -----
// ----------------------------------------------------------------------------
// hpv_fifo
// Small result queue: up to two results in a cycle, one out a cycle on pop_i.
// ----------------------------------------------------------------------------
`default_nettype none

module hpv_fifo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hpv_pkg::push_t               push_i,
  input  wire logic                         pop_i,
  output hpv_pkg::result_t                  head_o,
  output logic [hpv_pkg::CNT_BITS-1:0]      count_o
);

  hpv_pkg::result_t                mem_q [hpv_pkg::FIFO_DEPTH];
  logic [hpv_pkg::PTR_BITS-1:0]    wr_q, rd_q;
  logic [hpv_pkg::PTR_BITS-1:0]    wr_next;
  logic [hpv_pkg::CNT_BITS-1:0]    cnt_q, cnt_d;

  assign wr_next = wr_q + 1'b1;
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;
  assign cnt_d   = cnt_q + hpv_pkg::CNT_BITS'(push_i.count)
                 - hpv_pkg::CNT_BITS'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + hpv_pkg::PTR_BITS'(push_i.count);
      rd_q  <= rd_q + hpv_pkg::PTR_BITS'(pop_i);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hysteresis_peak_valley_detector.sv -----
// ----------------------------------------------------------------------------
// hysteresis_peak_valley_detector
// Reports local maxima and minima of a signed sample stream, confirmed once
// the signal moves more than a programmable threshold past the candidate.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Word
//   input     in         in_valid_i / in_ready_o    sample_i, stream_end_i
//   result    out        out_valid_o / out_ready_i  extremum_kind_o, position_o,
//                                                   level_o, run_last_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (hysteresis)
//
// One input word is taken per cycle. Its results are written into a four-entry
// result queue at the same clock edge, so the first result is visible in the
// cycle after acceptance; a word that ends a stream can produce two results,
// leaving one per cycle while out_ready_i is high. The input side stalls only
// when the queue could not hold two more results. Reset clears the candidates,
// the sample index, the queue and the threshold register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_peak_valley_detector (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [hpv_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                                  stream_end_i,

  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       extremum_kind_o,
  output logic [hpv_pkg::INDEX_BITS-1:0]             position_o,
  output logic signed [hpv_pkg::SAMPLE_BITS-1:0]     level_o,
  output logic                                       run_last_o,

  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [hpv_pkg::HYST_BITS-1:0]         cfg_data_i
);

  logic [hpv_pkg::HYST_BITS-1:0]  hyst_q;
  logic                           step;
  logic                           pop;
  hpv_pkg::push_t                 push;
  hpv_pkg::result_t               head;
  logic [hpv_pkg::CNT_BITS-1:0]   count;

  // The threshold register is always writable. The user must change it only
  // while the block is idle; this is not enforced, nor is back-pressure needed.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q <= '0;
    end else if (cfg_valid_i) begin
      hyst_q <= cfg_data_i;
    end
  end

  // Accept a sample whenever the queue has room for the worst case of two
  // results, independent of what the consumer does this cycle.
  assign in_ready_o = (count <= hpv_pkg::CNT_BITS'(hpv_pkg::FIFO_DEPTH - 2));
  assign step       = in_valid_i && in_ready_o;

  assign out_valid_o = (count != '0);
  assign pop         = out_valid_o && out_ready_i;

  hpv_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .sample_i     (sample_i),
    .stream_end_i (stream_end_i),
    .hyst_i       (hyst_q),
    .push_o       (push)
  );

  hpv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign extremum_kind_o = head.kind;
  assign position_o      = head.pos;
  assign level_o         = head.level;
  assign run_last_o      = head.last;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the hysteresis peak and valley detector
// Drives signed sample words with stream-end marks into the detector, keeps
// its own model of the candidate tracking, and checks every reported
// extremum field by field against the oldest expected one. A short table
// of hand-picked words comes first, then random wave-shaped streams under
// several threshold settings.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run, in clock cycles. The slowest legal run
  // is roughly 1.5k words sent with the longest sender gaps and behind the
  // slowest receiver pattern, plus the drains and the hold-off.
  localparam int unsigned RUN_LIMIT = 200_000;

  // Cycles the receiver refuses results once a hold-off starts, and the
  // number of accepted words between hold-offs.
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_SPACING = 2000;

  // Words per random phase.
  localparam int PHASE_WORDS = 160;

  // A table row whose expected count is PREDICTED is checked against the
  // model below; otherwise its results are typed into the row.
  localparam int PREDICTED = -1;

  // --------------------------------------------------------------------------
  // Block signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                                   clk_i        = 1'b0;
  logic                                   rst_ni       = 1'b0;
  logic                                   in_valid_i   = 1'b0;
  logic                                   in_ready_o;
  logic signed [hpv_pkg::SAMPLE_BITS-1:0] sample_i     = '0;
  logic                                   stream_end_i = 1'b0;
  logic                                   out_valid_o;
  logic                                   out_ready_i  = 1'b0;
  logic                                   extremum_kind_o;
  logic [hpv_pkg::INDEX_BITS-1:0]         position_o;
  logic signed [hpv_pkg::SAMPLE_BITS-1:0] level_o;
  logic                                   run_last_o;
  logic                                   cfg_valid_i  = 1'b0;
  logic                                   cfg_ready_o;
  logic [hpv_pkg::HYST_BITS-1:0]          cfg_data_i   = '0;

  hysteresis_peak_valley_detector u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .stream_end_i    (stream_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .extremum_kind_o (extremum_kind_o),
    .position_o      (position_o),
    .level_o         (level_o),
    .run_last_o      (run_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Directed table. Each row is one input word; typed results carry their
  // kind, position and level, and the last typed result of a row is the one
  // flagged as ending the word's results. The threshold is 0 throughout.
  // --------------------------------------------------------------------------
  typedef struct {
    int   word;
    bit   fin;
    int   fixed_n;
    logic k0;
    int   p0;
    int   l0;
    logic k1;
    int   p1;
    int   l1;
  } dir_row_t;

  dir_row_t dir_tab[23] = '{
    // Lone samples: the minimum and then the maximum, both at position 0.
    '{-32768, 1'b1, 2, hpv_pkg::KIND_MIN, 0, -32768, hpv_pkg::KIND_MAX, 0, -32768},
    '{ 32767, 1'b1, 2, hpv_pkg::KIND_MIN, 0,  32767, hpv_pkg::KIND_MAX, 0,  32767},
    '{    -1, 1'b1, 2, hpv_pkg::KIND_MIN, 0,     -1, hpv_pkg::KIND_MAX, 0,     -1},
    // An immediate fall confirms a maximum at position 0, which stays silent.
    '{   100, 1'b0, 0,         hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     0, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{    50, 1'b1, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    // Equal first pair starts by seeking a maximum.
    '{     5, 1'b0, 0,         hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     5, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     7, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     3, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{-32768, 1'b1, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    // Rising start: the minimum at position 0 stays silent, then full swings.
    '{     1, 1'b0, 0,         hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     2, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{ 32767, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{-32768, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{ 32767, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     0, 1'b1, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    // A maximum confirmed on the last word, then the pending minimum.
    '{    10, 1'b0, 0,         hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{    20, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     5, 1'b1, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    // Alternating bit patterns.
    '{ 21845, 1'b0, 0,         hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{-21846, 1'b0, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0},
    '{     0, 1'b1, PREDICTED, hpv_pkg::KIND_MAX, 0, 0, hpv_pkg::KIND_MAX, 0, 0}
  };

  // --------------------------------------------------------------------------
  // Detector model state: the search direction, both candidates, the next
  // sample index, and which kinds were already reported in this stream.
  // --------------------------------------------------------------------------
  logic [hpv_pkg::HYST_BITS-1:0]          threshold = '0;
  bit                                     hunt_peak = 1'b0;
  logic [hpv_pkg::INDEX_BITS-1:0]         peak_pos  = '0;
  logic signed [hpv_pkg::SAMPLE_BITS-1:0] peak_lvl  = '0;
  logic [hpv_pkg::INDEX_BITS-1:0]         dip_pos   = '0;
  logic signed [hpv_pkg::SAMPLE_BITS-1:0] dip_lvl   = '0;
  logic [hpv_pkg::INDEX_BITS-1:0]         next_idx  = '0;
  bit                                     peak_seen = 1'b0;
  bit                                     dip_seen  = 1'b0;

  hpv_pkg::result_t extrema_due[$];

  // Bookkeeping shared by the processes.
  int unsigned cycle_count = 0;
  int          row_tag     = PREDICTED;
  int          burst_left  = 0;
  int          words_in    = 0;
  int          streams_in  = 0;
  int          cfg_writes  = 0;
  int          maxima_ok   = 0;
  int          minima_ok   = 0;
  int          fails       = 0;

  // Random wave generator state.
  int wave_lvl  = 0;
  int wave_goal = 0;

  // Advances the model by one word. When keep is set, the extrema it
  // confirms are queued for checking; typed table rows only advance state.
  task automatic predict_word(input logic signed [hpv_pkg::SAMPLE_BITS-1:0] s,
                              input logic fin, input bit keep);
    hpv_pkg::result_t found[2];
    int               n;
    int               t;
    n = 0;
    t = int'(threshold);
    if (next_idx == 0) begin
      peak_pos = '0;
      dip_pos  = '0;
      peak_lvl = s;
      dip_lvl  = s;
    end else begin
      // The second sample fixes the initial direction.
      if (next_idx == 1) hunt_peak = (peak_lvl >= s);
      if (hunt_peak && int'(s) < int'(peak_lvl) - t) begin
        if (peak_pos != 0) begin
          found[n] = '{kind: hpv_pkg::KIND_MAX, pos: peak_pos, level: peak_lvl, last: 1'b0};
          n++;
          peak_seen = 1'b1;
        end
        hunt_peak = 1'b0;
        dip_pos   = next_idx;
        dip_lvl   = s;
      end else if (!hunt_peak && int'(s) > int'(dip_lvl) + t) begin
        if (dip_pos != 0) begin
          found[n] = '{kind: hpv_pkg::KIND_MIN, pos: dip_pos, level: dip_lvl, last: 1'b0};
          n++;
          dip_seen = 1'b1;
        end
        hunt_peak = 1'b1;
        peak_pos  = next_idx;
        peak_lvl  = s;
      end
      // Candidate update in the current direction.
      if (hunt_peak && s > peak_lvl) begin
        peak_pos = next_idx;
        peak_lvl = s;
      end else if (!hunt_peak && s < dip_lvl) begin
        dip_pos = next_idx;
        dip_lvl = s;
      end
    end
    // The index sticks at its top value.
    if (next_idx != '1) next_idx++;
    if (fin) begin
      // Kinds not reported during the stream are flushed, minimum first.
      if (!dip_seen && n < 2) begin
        found[n] = '{kind: hpv_pkg::KIND_MIN, pos: dip_pos, level: dip_lvl, last: 1'b0};
        n++;
      end
      if (!peak_seen && n < 2) begin
        found[n] = '{kind: hpv_pkg::KIND_MAX, pos: peak_pos, level: peak_lvl, last: 1'b0};
        n++;
      end
      hunt_peak = 1'b0;
      peak_pos  = '0;
      peak_lvl  = '0;
      dip_pos   = '0;
      dip_lvl   = '0;
      next_idx  = '0;
      peak_seen = 1'b0;
      dip_seen  = 1'b0;
    end
    if (n > 0) found[n-1].last = 1'b1;
    if (keep) begin
      for (int k = 0; k < n; k++) extrema_due = {extrema_due, found[k]};
    end
  endtask

  task automatic compare_field(input string what, input logic signed [31:0] want,
                               input logic signed [31:0] seen);
    if (seen !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Results leaving at an edge always come from words taken at
  // earlier edges, so the check runs before any new prediction is queued.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hpv_pkg::result_t got;
    hpv_pkg::result_t want;
    dir_row_t         row;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{kind: extremum_kind_o, pos: position_o, level: level_o, last: run_last_o};
        if (extrema_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, kind %0d position %0d level %0d last %0d",
                   $time, got.kind, got.pos, got.level, got.last);
        end else begin
          want = extrema_due.pop_front();
          compare_field("extremum_kind", want.kind, got.kind);
          compare_field("position", want.pos, got.pos);
          compare_field("level", want.level, got.level);
          compare_field("run_last", want.last, got.last);
          if (want.kind == hpv_pkg::KIND_MAX) maxima_ok++;
          else minima_ok++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        threshold = cfg_data_i;
        cfg_writes++;
      end
      if (in_valid_i && in_ready_o) begin
        words_in++;
        if (stream_end_i) streams_in++;
        if (row_tag >= 0 && dir_tab[row_tag].fixed_n != PREDICTED) begin
          row = dir_tab[row_tag];
          predict_word(sample_i, stream_end_i, 1'b0);
          for (int k = 0; k < row.fixed_n; k++) begin
            want.kind  = (k == 0) ? row.k0 : row.k1;
            want.pos   = (k == 0) ? row.p0[hpv_pkg::INDEX_BITS-1:0]
                                  : row.p1[hpv_pkg::INDEX_BITS-1:0];
            want.level = (k == 0) ? row.l0[hpv_pkg::SAMPLE_BITS-1:0]
                                  : row.l1[hpv_pkg::SAMPLE_BITS-1:0];
            want.last  = (k == row.fixed_n - 1);
            extrema_due = {extrema_due, want};
          end
        end else begin
          predict_word(sample_i, stream_end_i, 1'b1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It switches at random among four stall patterns, and after 1200
  // accepted words, then HOLD_SPACING words after each hold-off, it refuses
  // results for a long stretch while the sender keeps offering, so the result
  // queue fills and the input side has to stall.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int next_hold;
    mode      = 0;
    next_hold = 1200;
    forever begin
      @(posedge clk_i);
      if (words_in >= next_hold) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        next_hold = words_in + HOLD_SPACING;
      end else begin
        if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (cycle_count % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles, %0d results still due",
               $time, RUN_LIMIT, extrema_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Words go out in bursts of random length with random gaps
  // in between; each call returns at the edge where its word was accepted.
  // --------------------------------------------------------------------------
  task automatic push_word(input int s, input bit fin, input int tag);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    sample_i     <= s[hpv_pkg::SAMPLE_BITS-1:0];
    stream_end_i <= fin;
    row_tag      <= tag;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lets every due result drain, then waits on so that a word which produced
  // nothing is surely finished too.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (extrema_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_threshold(input int value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[hpv_pkg::HYST_BITS-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int clamp_sample(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Next sample of a wave that walks toward random goals. A goal is a random
  // level, a rail, or a level just past the threshold from the current one,
  // so that extrema get confirmed; about one sample in ten is plain noise.
  function automatic int wave_sample(input int thr);
    int step;
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
    if (wave_lvl == wave_goal || $urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0:       wave_goal = int'($urandom_range(0, 65535)) - 32768;
        1:       wave_goal = $urandom_range(0, 1) ? 32767 : -32768;
        default: wave_goal = wave_lvl + ($urandom_range(0, 1) ? 1 : -1) *
                             (thr + int'($urandom_range(1, 300)));
      endcase
      wave_goal = clamp_sample(wave_goal);
    end
    step = int'($urandom_range(1, 1 + thr / 3 + 200));
    if (wave_lvl < wave_goal) wave_lvl = (wave_goal - wave_lvl < step) ? wave_goal
                                                                      : wave_lvl + step;
    else if (wave_lvl > wave_goal) wave_lvl = (wave_lvl - wave_goal < step) ? wave_goal
                                                                           : wave_lvl - step;
    return wave_lvl;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int thr_plan[9];
    int thr;
    int sent;
    int len;
    // -1 stands for a threshold drawn at random.
    thr_plan = '{0, 32767, 1, 500, -1, 4000, -1, 12000, 100};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, at a threshold of zero.
    set_threshold(0);
    foreach (dir_tab[i]) push_word(dir_tab[i].word, dir_tab[i].fin, i);

    // Random streams under each planned threshold. Each phase closes its
    // last stream so that the threshold changes only between streams.
    foreach (thr_plan[p]) begin
      thr = (thr_plan[p] < 0) ? int'($urandom_range(0, 32767)) : thr_plan[p];
      set_threshold(thr);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = 2;
          default: len = $urandom_range(3, 60);
        endcase
        if (sent + len > PHASE_WORDS) len = PHASE_WORDS - sent;
        for (int i = 0; i < len; i++) push_word(wave_sample(thr), i == len - 1, PREDICTED);
        sent += len;
      end
    end

    drain_results();

    $display("Sent %0d words in %0d streams over %0d threshold writes, with receiver",
             words_in, streams_in, cfg_writes);
    $display("stalls and one long hold-off; checked %0d maxima and %0d minima, %0d mismatches.",
             maxima_ok, minima_ok, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hpv_pkg.sv
rtl/hpv_core.sv
rtl/hpv_fifo.sv
rtl/hysteresis_peak_valley_detector.sv
sim/tb_top.sv
